/* design/knn_pkg.sv */
// shared constants and types for the knn linear scan top-k unit
package knn_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_DIMS   = 64;
  localparam int MAX_K      = 16;

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int DW    = $clog2(MAX_DIMS);
  localparam int KW    = $clog2(MAX_K);
  localparam int CW    = 16;
  localparam int DISTW = 38;

  localparam logic [DISTW-1:0] DIST_ONES = {DISTW{1'b1}};

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_DIMS      = 2'd0;
  localparam logic [1:0] REG_POINTS    = 2'd1;
  localparam logic [1:0] REG_NEIGHBORS = 2'd2;

  // scan sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CLR  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_INS  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // insertion request into the sorted list
  typedef struct packed {
    logic             clear;
    logic             ins;
    logic [DISTW-1:0] sq_dist;
    logic [KW:0]      k;
  } ins_req_t;

endpackage

/* design/knn_linear_scan_topk_unit.sv */
// top level of the knn linear scan top-k unit
// Loads and query coordinates are accepted while idle. The last query coordinate
// starts a scan: a clear step, then for each point an accumulate phase, paced by
// the single point store read port, its read pipeline (a_r, then a2_r) and one
// shared squared-difference accumulator, then an insert into the sorted list;
// then k results are shown one per cycle while out_tready is high. The point
// store and query vector are undefined until written. in_tready is low during
// a scan.
module knn_linear_scan_topk_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // point_index, dim_index, coord
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // rank, sq_distance
  output logic        out_tuser,  // valid_res
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int PW = knn_pkg::PW;
  localparam int DW = knn_pkg::DW;
  localparam int KW = knn_pkg::KW;

  knn_pkg::state_t state_r, state_nxt;

  logic [6:0]  dims_r;
  logic [10:0] np_r;
  logic [4:0]  nb_r;

  logic [15:0] point_store [knn_pkg::MAX_POINTS*knn_pkg::MAX_DIMS];
  logic [15:0] query_vector [knn_pkg::MAX_DIMS];

  logic [PW-1:0] pidx;
  logic [DW-1:0] didx;
  logic [15:0]   coord;
  logic          cmd;
  assign pidx  = in_tdata[PW-1:0];
  assign didx  = in_tdata[PW+DW-1:PW];
  assign coord = in_tdata[PW+DW+15:PW+DW];
  assign cmd   = in_tuser;

  // effective configuration
  logic [DW:0]  nd;
  logic [PW:0]  np;
  logic [KW:0]  kk;
  always_comb begin
    if (dims_r == 7'd0) nd = (DW+1)'(1);
    else if (dims_r > 7'(knn_pkg::MAX_DIMS)) nd = (DW+1)'(knn_pkg::MAX_DIMS);
    else nd = (DW+1)'(dims_r);
    if (np_r > 11'(knn_pkg::MAX_POINTS)) np = (PW+1)'(knn_pkg::MAX_POINTS);
    else np = (PW+1)'(np_r);
    if (nb_r == 5'd0) kk = (KW+1)'(1);
    else if (nb_r > 5'(knn_pkg::MAX_K)) kk = (KW+1)'(knn_pkg::MAX_K);
    else kk = (KW+1)'(nb_r);
  end

  logic in_acc;
  assign in_tready = (state_r == knn_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  logic start;
  assign start = in_acc && (cmd == knn_pkg::CMD_QUERY) && ((DW+1)'(didx) == nd - 1'b1);

  // scan counters and pipeline
  logic [PW:0]   p_r, p_nxt;
  logic [DW:0]   d_r, d_nxt;
  logic          rv_r;
  logic [DW-1:0] rd_d_r;
  logic [15:0]   a_r, b_r;
  logic [37:0]   acc_r, acc_nxt;
  logic [KW:0]   r_r, r_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 7'd1;
      np_r   <= 11'd1;
      nb_r   <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        knn_pkg::REG_DIMS:      dims_r <= cfg_wdata[6:0];
        knn_pkg::REG_POINTS:    np_r   <= cfg_wdata;
        knn_pkg::REG_NEIGHBORS: nb_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // store writes and registered reads
  logic rd_en;
  assign rd_en = (state_r == knn_pkg::ST_ACC) && (d_r < nd);
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (cmd == knn_pkg::CMD_LOAD) point_store[{pidx, didx}] <= coord;
      else query_vector[didx] <= coord;
    end
    a_r    <= point_store[{p_r[PW-1:0], d_r[DW-1:0]}];
    rd_d_r <= d_r[DW-1:0];
  end
  always_ff @(posedge clk) b_r <= query_vector[rd_d_r];

  // delayed read valid; the query read is registered after the store read, so a_r is held in a2_r
  logic rv2_r;
  logic [15:0] a2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r  <= 1'b0;
      rv2_r <= 1'b0;
    end else begin
      rv_r  <= rd_en;
      rv2_r <= rv_r;
    end
    a2_r <= a_r;
  end

  // shared squared-difference unit with saturation
  logic [15:0] diff;
  logic [31:0] sq;
  logic [38:0] sum;
  assign diff = (a2_r > b_r) ? (a2_r - b_r) : (b_r - a2_r);
  assign sq   = diff * diff;
  assign sum  = {1'b0, acc_r} + 39'(sq);

  knn_pkg::ins_req_t req;
  logic [knn_pkg::DISTW-1:0] rd_dist;

  always_comb begin
    state_nxt   = state_r;
    p_nxt       = p_r;
    d_nxt       = d_r;
    acc_nxt     = acc_r;
    r_nxt       = r_r;
    req.clear   = 1'b0;
    req.ins     = 1'b0;
    req.sq_dist = acc_r;
    req.k       = kk;
    if (rv2_r) begin
      if (sum >= 39'(knn_pkg::DIST_ONES)) acc_nxt = knn_pkg::DIST_ONES - 1'b1;
      else acc_nxt = sum[37:0];
    end
    unique case (state_r)
      knn_pkg::ST_IDLE: begin
        if (start) state_nxt = knn_pkg::ST_CLR;
      end
      knn_pkg::ST_CLR: begin
        req.clear = 1'b1;
        p_nxt     = '0;
        d_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = (np == '0) ? knn_pkg::ST_OUT : knn_pkg::ST_ACC;
        r_nxt     = '0;
      end
      knn_pkg::ST_ACC: begin
        if (d_r < nd + (DW+1)'(1)) d_nxt = d_r + 1'b1;
        else if (!rv_r && !rv2_r) state_nxt = knn_pkg::ST_INS;
      end
      knn_pkg::ST_INS: begin
        req.ins = 1'b1;
        acc_nxt = '0;
        d_nxt   = '0;
        p_nxt   = p_r + 1'b1;
        if (p_r + 1'b1 == np) begin
          state_nxt = knn_pkg::ST_OUT;
          r_nxt     = '0;
        end else state_nxt = knn_pkg::ST_ACC;
      end
      knn_pkg::ST_OUT: begin
        if (out_tready) begin
          r_nxt = r_r + 1'b1;
          if (r_r + 1'b1 == kk) state_nxt = knn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = knn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= knn_pkg::ST_IDLE;
      p_r     <= '0;
      d_r     <= '0;
      r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      d_r     <= d_nxt;
      r_r     <= r_nxt;
    end
    acc_r <= acc_nxt;
  end

  knn_topk_list u_list (
    .clk     (clk),
    .req     (req),
    .rd_idx  (r_r[KW-1:0]),
    .rd_dist (rd_dist)
  );

  // result output
  assign out_tvalid = (state_r == knn_pkg::ST_OUT);
  assign out_tdata  = {6'd0, rd_dist, r_r[KW-1:0]};
  assign out_tuser  = (rd_dist != knn_pkg::DIST_ONES);
  assign out_tlast  = (r_r + 1'b1 == kk);

  // a scan never starts while results are pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready during output");
  // result rank stays inside k
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (r_r < kk))
    else $error("rank beyond k");
  // insert step follows accumulate
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == knn_pkg::ST_INS) |-> $past(state_r) == knn_pkg::ST_ACC)
    else $error("insert without accumulate");

endmodule

/* design/knn_topk_list.sv */
// sorted list of the k smallest distances, one insertion per request
module knn_topk_list (
  input  logic                      clk,
  input  knn_pkg::ins_req_t         req,
  input  logic [knn_pkg::KW-1:0]    rd_idx,
  output logic [knn_pkg::DISTW-1:0] rd_dist
);

  logic [knn_pkg::DISTW-1:0] best_r [knn_pkg::MAX_K];
  logic [knn_pkg::MAX_K-1:0] lt;

  // per-entry compare, entries beyond k never take an inserted value
  always_comb begin
    for (int i = 0; i < knn_pkg::MAX_K; i++) begin
      lt[i] = (req.sq_dist < best_r[i]) && ((knn_pkg::KW+1)'(i) < req.k);
    end
  end

  // shift entries at and after the first smaller slot
  always_ff @(posedge clk) begin
    if (req.clear) begin
      for (int i = 0; i < knn_pkg::MAX_K; i++) best_r[i] <= knn_pkg::DIST_ONES;
    end else if (req.ins) begin
      for (int i = 0; i < knn_pkg::MAX_K; i++) begin
        if (lt[i]) begin
          if (i == 0) best_r[i] <= req.sq_dist;
          else if (!lt[i-1]) best_r[i] <= req.sq_dist;
          else best_r[i] <= best_r[i-1];
        end
      end
    end
  end

  assign rd_dist = best_r[rd_idx];

endmodule
